// ----- hw/rtl/bus_memory_io_responder_core_defines.svh -----
// Assertion macros for the bus memory and I/O responder.
// Used by the top level only; depends on nothing else.
`ifndef BUS_MEMORY_IO_RESPONDER_CORE_DEFINES_SVH
`define BUS_MEMORY_IO_RESPONDER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMIO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bmio_pkg.sv -----
// Shared types and constants for the bus memory and I/O responder.
// Used by the top level, bmio_ram and bmio_io; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmio_pkg;

  // Memory size in address bits; the I/O decode always uses all 16 bits.
  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_POLL  = 2'd3
  } kind_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_PORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_PORT  = 1'b1;
  localparam logic [7:0] SERIAL_PORT_RESET = 8'd160;
  localparam logic [7:0] BLOCK_PORT_RESET  = 8'd128;

  // Address map.
  localparam logic [15:0] IO_FIRST   = 16'hFF00;
  localparam logic [15:0] IO_PAGE_END = 16'hFFF0;
  localparam logic [15:0] IO_LAST    = 16'hFFFD;
  localparam logic [15:0] RESET_VEC  = 16'hFFFE;
  localparam logic [15:0] LOC_FRAME  = 16'hFF03;

  // Low bytes inside the I/O page.
  localparam logic [7:0] LO_HALT_LAST = 8'h01;
  localparam logic [7:0] LO_PIA_DATA  = 8'h02;
  localparam logic [7:0] LO_PIA_CTRL  = 8'h03;
  localparam logic [7:0] SER_DATA_OFS = 8'd1;
  localparam logic [7:0] BLK_STAT_OFS = 8'd7;

  localparam logic [7:0] FRAME_FLAG_SET = 8'h80;
  localparam logic [7:0] FRAME_FLAG_CLR = 8'h7F;
  localparam logic [7:0] SER_STATUS_BASE = 8'h02;
  localparam logic [7:0] BLK_STAT_VALUE  = 8'h01;
  localparam logic [7:0] PIA_DATA_VALUE  = 8'hFF;

  localparam logic [7:0] CHAR_MIN = 8'd1;
  localparam logic [7:0] CHAR_MAX = 8'd126;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        char_valid;
    logic [7:0]  char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       char_taken;
  } out_item_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } mem_wr_t;

  typedef struct packed {
    logic started;
    logic irq;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmio_if.sv -----
// Valid/ready channel interfaces for items into and results out of the responder.
// Depends on nothing; the payload follows the item fields of the block.
`timescale 1ns / 1ps
`default_nettype none

interface bmio_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        char_valid;
  logic [7:0]  char_in;

  modport source (output valid, kind, addr, wdata, char_valid, char_in, input ready);
  modport sink   (input valid, kind, addr, wdata, char_valid, char_in, output ready);
endinterface

interface bmio_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq;
  logic       tx_valid;
  logic [7:0] tx_char;
  logic       char_taken;

  modport source (output valid, rdata, irq, tx_valid, tx_char, char_taken, input ready);
  modport sink   (input valid, rdata, irq, tx_valid, tx_char, char_taken, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bus_memory_io_responder_core.sv -----
// Top level of the bus memory and I/O responder.
// Depends on bmio_pkg, bmio_if, bmio_ram, bmio_io and the assertion macro header.
//
// Usage: each item on in_i is one CPU bus read, one bus write, one frame tick or
// one serial poll. Every item produces exactly one result item on out_o, in
// order, carrying the read byte, the interrupt level after the item, a transmit
// character strobe and the flag that tells the character feeder to advance.
// Both channels move an item when valid and ready are high at a clock edge.
// The item is registered while the memory is read; the decode and state update
// then run on it, and the result register is loaded as it leaves the decode
// stage. Throughput is one item per cycle while out_o takes results, set by the
// single synchronous memory read followed by the write in the decode cycle. A
// write in the decode cycle is forwarded to an item that reads the same address
// in that cycle. The serial and block port addresses are set through the cfg
// write port; the user must do so only while the block is idle, which the block
// does not enforce. Reset clears all flags, the started condition and location
// FF03; the rest of the memory keeps its preloaded image and is otherwise
// undefined. When out_o stalls, the result holds, one more item is taken into
// an empty decode stage, and then in_i.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "bus_memory_io_responder_core_defines.svh"

module bus_memory_io_responder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bmio_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [7:0]                       cfg_wdata_i,
  bmio_in_if.sink                          in_i,
  bmio_out_if.source                       out_o
);
  import bmio_pkg::*;

  // Configuration registers.
  logic [7:0] serial_port_low_q;
  logic [7:0] block_port_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_port_low_q <= SERIAL_PORT_RESET;
      block_port_low_q  <= BLOCK_PORT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SERIAL_PORT: serial_port_low_q <= cfg_wdata_i;
        CFG_BLOCK_PORT:  block_port_low_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Handshake control. The decode stage moves on whenever the result register
  // is free or being emptied; a new item enters an empty or freeing decode stage.
  logic      s1_valid_q;
  logic      s1_fire;
  logic      in_acc;
  logic      out_valid_q;
  in_item_t  in_item;
  in_item_t  s1_item_q;
  logic      s1_fwd_q;
  logic [7:0] s1_fwd_data_q;
  out_item_t out_q;
  out_item_t result;
  mem_wr_t   mem_wr;
  status_t   status;
  logic [7:0] ram_rdata;
  logic [7:0] mem_data;

  assign s1_fire     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign in_acc      = in_i.valid && in_i.ready;

  assign in_item.kind       = in_i.kind;
  assign in_item.addr       = in_i.addr;
  assign in_item.wdata      = in_i.wdata;
  assign in_item.char_valid = in_i.char_valid;
  assign in_item.char_in    = in_i.char_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_acc || (s1_valid_q && !s1_fire);
      out_valid_q <= s1_fire || (out_valid_q && !out_o.ready);
    end
  end

  // The memory read of the next item overlaps the write of the current one,
  // so a hit on the written address takes the write data instead.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q     <= in_item;
      s1_fwd_q      <= mem_wr.en && (mem_wr.addr == in_i.addr[ADDR_BITS-1:0]);
      s1_fwd_data_q <= mem_wr.data;
    end
    if (s1_fire) begin
      out_q <= result;
    end
  end

  bmio_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.en),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .re_i    (in_acc),
    .raddr_i (in_i.addr[ADDR_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign mem_data = s1_fwd_q ? s1_fwd_data_q : ram_rdata;

  bmio_io u_io (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (s1_fire),
    .item_i            (s1_item_q),
    .mem_data_i        (mem_data),
    .serial_port_low_i (serial_port_low_q),
    .block_port_low_i  (block_port_low_q),
    .result_o          (result),
    .mem_wr_o          (mem_wr),
    .status_o          (status)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.rdata      = out_q.rdata;
  assign out_o.irq        = out_q.irq;
  assign out_o.tx_valid   = out_q.tx_valid;
  assign out_o.tx_char    = out_q.tx_char;
  assign out_o.char_taken = out_q.char_taken;

  // The reported interrupt level matches the flag state left by the item.
  `BMIO_ASSERT_NEXT(a_irq_matches_state, clk_i, rst_ni, s1_fire, out_q.irq == status.irq, "irq result differs from flag state")
  // Once the reset vector has been fetched, writes stay enabled.
  `BMIO_ASSERT_NEXT(a_started_sticky, clk_i, rst_ni, status.started, status.started, "started condition dropped")
  // A decode stage that empties without a new item stays empty.
  `BMIO_ASSERT_NEXT(a_stage_drains, clk_i, rst_ni, s1_fire && !in_acc, !s1_valid_q, "decode stage holds a stale item")
  // Memory is only written while the decode stage holds a write item.
  `BMIO_ASSERT_NOW(a_write_on_fire, clk_i, rst_ni, mem_wr.en && !s1_fire, s1_item_q.kind == KIND_WRITE, "memory write outside a write item")

endmodule

`default_nettype wire

// ----- hw/rtl/bmio_ram.sv -----
// Byte-wide main memory with one write port and one registered read port.
// Depends on bmio_pkg for the address width.
`timescale 1ns / 1ps
`default_nettype none

module bmio_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bmio_pkg::ADDR_BITS-1:0] waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [bmio_pkg::ADDR_BITS-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);
  import bmio_pkg::*;

  logic [7:0] mem_q [MEM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bmio_io.sv -----
// I/O page emulation: decodes one item, updates the flags and location FF03.
// Depends on bmio_pkg; produces the result and the memory write request.
`timescale 1ns / 1ps
`default_nettype none

module bmio_io (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  bmio_pkg::in_item_t  item_i,
  input  logic [7:0]          mem_data_i,
  input  logic [7:0]          serial_port_low_i,
  input  logic [7:0]          block_port_low_i,
  output bmio_pkg::out_item_t result_o,
  output bmio_pkg::mem_wr_t   mem_wr_o,
  output bmio_pkg::status_t   status_o
);
  import bmio_pkg::*;

  logic       started_q, started_d;
  logic       frame_en_q, frame_en_d;
  logic       frame_pend_q, frame_pend_d;
  logic       ser_en_q, ser_en_d;
  logic       ser_pend_q, ser_pend_d;
  logic       rx_ready_q, rx_ready_d;
  logic [7:0] rx_char_q, rx_char_d;
  // Location FF03 lives here so that a tick or a flag clear needs no memory access.
  logic [7:0] ff03_q, ff03_d;

  logic [7:0] lo;
  logic [7:0] ser_data_lo;
  logic [7:0] blk_stat_lo;
  logic       in_page;
  logic       io_win;
  logic       is_ff03_loc;
  logic [7:0] mem_byte;
  logic [7:0] data;
  logic       reading;

  always_comb begin
    started_d    = started_q;
    frame_en_d   = frame_en_q;
    frame_pend_d = frame_pend_q;
    ser_en_d     = ser_en_q;
    ser_pend_d   = ser_pend_q;
    rx_ready_d   = rx_ready_q;
    rx_char_d    = rx_char_q;
    ff03_d       = ff03_q;
    result_o     = '0;
    mem_wr_o     = '0;

    lo          = item_i.addr[7:0];
    ser_data_lo = serial_port_low_i + SER_DATA_OFS;
    blk_stat_lo = block_port_low_i + BLK_STAT_OFS;
    in_page     = (item_i.addr >= IO_FIRST) && (item_i.addr < IO_PAGE_END);
    io_win      = started_q && (item_i.addr >= IO_FIRST) && (item_i.addr <= IO_LAST);
    is_ff03_loc = (item_i.addr[ADDR_BITS-1:0] == LOC_FRAME[ADDR_BITS-1:0]);
    mem_byte    = is_ff03_loc ? ff03_q : mem_data_i;
    data        = item_i.wdata;
    reading     = 1'b0;

    case (item_i.kind)
      KIND_READ: begin
        reading = 1'b1;
        data    = mem_byte;
        if (in_page) begin
          if ((lo <= LO_HALT_LAST) || (lo == LO_PIA_CTRL)) begin
            data = mem_byte;
          end else if (lo == LO_PIA_DATA) begin
            data         = PIA_DATA_VALUE;
            ff03_d       = ff03_q & FRAME_FLAG_CLR;
            frame_pend_d = 1'b0;
          end else if (lo == serial_port_low_i) begin
            data       = SER_STATUS_BASE | {ser_pend_q, 6'b0, rx_ready_q};
            ser_pend_d = 1'b0;
          end else if (lo == ser_data_lo) begin
            data       = rx_ready_q ? rx_char_q : 8'h00;
            rx_ready_d = 1'b0;
          end else if (lo == blk_stat_lo) begin
            data = BLK_STAT_VALUE;
          end
        end
        result_o.rdata = data;
        if (item_i.addr == RESET_VEC) begin
          started_d = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (started_q) begin
          mem_wr_o.en   = 1'b1;
          mem_wr_o.addr = item_i.addr[ADDR_BITS-1:0];
          mem_wr_o.data = item_i.wdata;
          if (is_ff03_loc) begin
            ff03_d = item_i.wdata;
          end
        end
      end
      KIND_TICK: begin
        ff03_d = ff03_q | FRAME_FLAG_SET;
        if (frame_en_q) begin
          frame_pend_d = 1'b1;
        end
      end
      KIND_POLL: begin
        if (!rx_ready_q) begin
          if (item_i.char_valid && (item_i.char_in >= CHAR_MIN) &&
              (item_i.char_in <= CHAR_MAX)) begin
            rx_char_d  = (item_i.char_in == CHAR_LF) ? CHAR_CR : item_i.char_in;
            rx_ready_d = 1'b1;
            ser_pend_d = 1'b1;
            result_o.char_taken = 1'b1;
          end else begin
            rx_char_d  = 8'h00;
            rx_ready_d = 1'b0;
            ser_pend_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // Port side effects once the reset vector has been fetched.
    if (io_win && ((item_i.kind == KIND_READ) || (item_i.kind == KIND_WRITE))) begin
      if (lo <= LO_PIA_DATA) begin
        // PIA0 data and the halting reads have no side effect here.
      end else if (lo == LO_PIA_CTRL) begin
        frame_en_d = data[0];
      end else if (lo == serial_port_low_i) begin
        if (!reading) begin
          ser_en_d = item_i.wdata[7];
        end
      end else if (lo == ser_data_lo) begin
        if (!reading) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_char  = item_i.wdata;
        end
      end
    end

    result_o.irq = (frame_en_d & frame_pend_d) | (ser_en_d & ser_pend_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      frame_en_q   <= 1'b0;
      frame_pend_q <= 1'b0;
      ser_en_q     <= 1'b0;
      ser_pend_q   <= 1'b0;
      rx_ready_q   <= 1'b0;
      rx_char_q    <= 8'h00;
      ff03_q       <= 8'h00;
    end else if (fire_i) begin
      started_q    <= started_d;
      frame_en_q   <= frame_en_d;
      frame_pend_q <= frame_pend_d;
      ser_en_q     <= ser_en_d;
      ser_pend_q   <= ser_pend_d;
      rx_ready_q   <= rx_ready_d;
      rx_char_q    <= rx_char_d;
      ff03_q       <= ff03_d;
    end
  end

  assign status_o.started = started_q;
  assign status_o.irq     = (frame_en_q & frame_pend_q) | (ser_en_q & ser_pend_q);

endmodule

`default_nettype wire
